@@ hdl/rsbk_pkg.sv @@
// Shared types and constants for the record sorter.
package rsbk_pkg;

  localparam int MAX_ENTRIES_DEF = 64;

  localparam int KEY_W   = 5;
  localparam int CLASS_W = 8;
  localparam int MULT_W  = 8;
  localparam int COORD_W = 64;

  // One stored record, as kept in the record memory.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [CLASS_W-1:0] cls;
    logic [MULT_W-1:0]  mult;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } rec_t;

  // Source of the data written into the record memory.
  typedef enum logic [1:0] {
    WR_INPUT = 2'd0,
    WR_CARRY = 2'd1,
    WR_READ  = 2'd2
  } wr_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    rd_en;
    logic    carry_ld;
    logic    out_ld;
    logic    out_last;
    logic    out_dropped;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic swap;
    logic out_free;
  } dp_stat_t;

endpackage

@@ hdl/rsbk_dp.sv @@
// Datapath of the record sorter: record memory, carry register and output register.
module rsbk_dp #(
  parameter int MAX_ENTRIES = rsbk_pkg::MAX_ENTRIES_DEF,
  parameter int AW          = $clog2(MAX_ENTRIES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rsbk_pkg::dp_cmd_t  cmd,
  input  logic [AW-1:0]      wr_addr,
  input  logic [AW-1:0]      rd_addr,
  output rsbk_pkg::dp_stat_t stat,
  input  rsbk_pkg::rec_t     in_rec,
  output rsbk_pkg::rec_t     out_rec,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_last,
  output logic               out_dropped
);
  import rsbk_pkg::*;

  rec_t mem [MAX_ENTRIES];
  rec_t rd_q_r;
  rec_t carry_r;
  rec_t wr_data;
  rec_t out_rec_r;
  logic out_valid_r, out_valid_nxt;
  logic out_last_r;
  logic out_dropped_r;

  always_comb begin
    case (cmd.wr_sel)
      WR_INPUT: wr_data = in_rec;
      WR_CARRY: wr_data = carry_r;
      WR_READ:  wr_data = rd_q_r;
      default:  wr_data = carry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
    if (cmd.carry_ld) begin
      carry_r <= rd_q_r;
    end
    if (cmd.out_ld) begin
      out_rec_r     <= rd_q_r;
      out_last_r    <= cmd.out_last;
      out_dropped_r <= cmd.out_dropped;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Strictly greater keeps equal keys in arrival order.
  assign stat.swap     = carry_r.key > rd_q_r.key;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_rec     = out_rec_r;
  assign out_valid   = out_valid_r;
  assign out_last    = out_last_r;
  assign out_dropped = out_dropped_r;

endmodule

@@ hdl/rsbk_ctrl.sv @@
// Controller of the record sorter: load, bubble-sort passes and emission sequencing.
module rsbk_ctrl #(
  parameter int MAX_ENTRIES = rsbk_pkg::MAX_ENTRIES_DEF,
  parameter int AW          = $clog2(MAX_ENTRIES),
  parameter int CW          = $clog2(MAX_ENTRIES + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_final,
  input  rsbk_pkg::dp_stat_t stat,
  output rsbk_pkg::dp_cmd_t  cmd,
  output logic [AW-1:0]      wr_addr,
  output logic [AW-1:0]      rd_addr
);
  import rsbk_pkg::*;

  typedef enum logic [6:0] {
    S_LOAD    = 7'b0000001,
    S_CLOSE   = 7'b0000010,
    S_FIRST   = 7'b0000100,
    S_CMP     = 7'b0001000,
    S_TAIL    = 7'b0010000,
    S_EMIT_RD = 7'b0100000,
    S_EMIT    = 7'b1000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] pend_r, pend_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic          is_last;

  assign is_last = (CW'(k_r) == (count_r - CW'(1)));

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    j_nxt       = j_r;
    pend_nxt    = pend_r;
    k_nxt       = k_r;
    cmd         = '0;
    cmd.wr_sel  = WR_INPUT;
    wr_addr     = '0;
    rd_addr     = '0;
    in_ready    = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (count_r < CW'(MAX_ENTRIES)) begin
            cmd.wr_en = 1'b1;
            wr_addr   = count_r[AW-1:0];
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_final) begin
            state_nxt = S_CLOSE;
          end
        end
      end
      S_CLOSE: begin
        if (count_r == '0) begin
          ovf_nxt   = 1'b0;
          state_nxt = S_LOAD;
        end else if (count_r == CW'(1)) begin
          k_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr   = '0;
          pend_nxt  = AW'(count_r - CW'(1));
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        cmd.carry_ld = 1'b1;
        cmd.rd_en    = 1'b1;
        rd_addr      = AW'(1);
        j_nxt        = AW'(1);
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        cmd.wr_en    = 1'b1;
        wr_addr      = j_r - AW'(1);
        cmd.wr_sel   = stat.swap ? WR_READ : WR_CARRY;
        cmd.carry_ld = !stat.swap;
        if (j_r == pend_r) begin
          state_nxt = S_TAIL;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr   = j_r + AW'(1);
          j_nxt     = j_r + AW'(1);
        end
      end
      S_TAIL: begin
        cmd.wr_en  = 1'b1;
        wr_addr    = pend_r;
        cmd.wr_sel = WR_CARRY;
        if (pend_r == AW'(1)) begin
          k_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          pend_nxt  = pend_r - AW'(1);
          cmd.rd_en = 1'b1;
          rd_addr   = '0;
          state_nxt = S_FIRST;
        end
      end
      S_EMIT_RD: begin
        cmd.rd_en = 1'b1;
        rd_addr   = k_r;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_ld      = 1'b1;
          cmd.out_last    = is_last;
          cmd.out_dropped = ovf_r;
          if (is_last) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + AW'(1);
            cmd.rd_en = 1'b1;
            rd_addr   = k_r + AW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
      j_r     <= '0;
      pend_r  <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      j_r     <= j_nxt;
      pend_r  <= pend_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

@@ hdl/record_sort_by_key.sv @@
// Top level of the record sorter: stable ascending sort of a set of records by key.
//
// Usage: records arrive on the in_ channel (valid/ready), one request per cycle
// while the block is loading. Each request carries a key, a class id, a multiplicity
// and three 64-bit words that are stored as raw bits. The request with
// in_final_record set closes the set. Up to MAX_ENTRIES records are kept; later
// ones are dropped and every result of that set then shows out_dropped.
// After the closing request the block sorts the stored records with a bubble sort
// over the record memory: one compare per cycle, with the running maximum held in
// a carry register; a set of fewer than two records is not sorted.
// Results then leave on the out_ channel at one request per cycle while out_ready
// is high, in ascending key order, equal keys in arrival order, out_last on the
// final one. A set with no stored record produces no result.
// A stalled receiver simply holds the emission; the output register keeps its
// request until taken. Loading of the next set starts as soon as the last result
// is in the output register. During sort and emission in_ready is low.
// Reset (rst_n low, synchronous) empties the set and clears the drop flag and the
// output valid; the record memory needs no clearing.
module record_sort_by_key #(
  parameter int MAX_ENTRIES = rsbk_pkg::MAX_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rsbk_pkg::KEY_W-1:0]     in_sort_key,
  input  logic [rsbk_pkg::CLASS_W-1:0]   in_class_id,
  input  logic [rsbk_pkg::MULT_W-1:0]    in_multiplicity,
  input  logic [rsbk_pkg::COORD_W-1:0]   in_coord_x,
  input  logic [rsbk_pkg::COORD_W-1:0]   in_coord_y,
  input  logic [rsbk_pkg::COORD_W-1:0]   in_coord_z,
  input  logic                           in_final_record,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rsbk_pkg::KEY_W-1:0]     out_key,
  output logic [rsbk_pkg::CLASS_W-1:0]   out_class,
  output logic [rsbk_pkg::MULT_W-1:0]    out_mult,
  output logic [rsbk_pkg::COORD_W-1:0]   out_x,
  output logic [rsbk_pkg::COORD_W-1:0]   out_y,
  output logic [rsbk_pkg::COORD_W-1:0]   out_z,
  output logic                           out_last,
  output logic                           out_dropped
);
  import rsbk_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  rec_t          in_rec;
  rec_t          out_rec;

  // Pack the incoming request into one memory word.
  always_comb begin
    in_rec.key  = in_sort_key;
    in_rec.cls  = in_class_id;
    in_rec.mult = in_multiplicity;
    in_rec.x    = in_coord_x;
    in_rec.y    = in_coord_y;
    in_rec.z    = in_coord_z;
  end

  rsbk_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_final (in_final_record),
    .stat     (stat),
    .cmd      (cmd),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr)
  );

  rsbk_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .AW          (AW)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .wr_addr     (wr_addr),
    .rd_addr     (rd_addr),
    .stat        (stat),
    .in_rec      (in_rec),
    .out_rec     (out_rec),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_last    (out_last),
    .out_dropped (out_dropped)
  );

  // Unpack the output register onto the result ports.
  assign out_key   = out_rec.key;
  assign out_class = out_rec.cls;
  assign out_mult  = out_rec.mult;
  assign out_x     = out_rec.x;
  assign out_y     = out_rec.y;
  assign out_z     = out_rec.z;

endmodule
